/* rtl/dmcmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dmcmp_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned IDX_BITS_W   = 4;
  localparam int unsigned SPAN_BASE_W  = 48;
  localparam int unsigned SPAN_LINES_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LINES = 2'd2;

  localparam logic [IDX_BITS_W-1:0]   IDX_BITS_RST   = 4'd12;
  localparam logic [SPAN_BASE_W-1:0]  SPAN_BASE_RST  = 48'd0;
  localparam logic [SPAN_LINES_W-1:0] SPAN_LINES_RST = 17'd65536;

  // 64-byte lines
  localparam int unsigned LINE_SHIFT = 6;

  // distinct-line map is stored as rows of 64 bits
  localparam int unsigned MAP_ROW_BITS = 64;
  localparam int unsigned MAP_BIT_W    = 6;

  localparam int unsigned COUNT_W     = 64;
  localparam int unsigned OUT_FIELD_W = 3 + 5 * COUNT_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_LOOK,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic load_addr;
    logic calc_en;
    logic span_en;
    logic update_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

/* rtl/dmcmp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dmcmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dmcmp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dmcmp_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire dmcmp_pkg::ctrl_status_t status_i,
  output dmcmp_pkg::ctrl_cmd_t         cmd_o
);

  dmcmp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmcmp_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmcmp_pkg::S_CLEAR: begin
        if (status_i.clr_done) state_d = dmcmp_pkg::S_IDLE;
      end
      dmcmp_pkg::S_IDLE: begin
        if (in_valid_i) state_d = dmcmp_pkg::S_CALC;
      end
      dmcmp_pkg::S_CALC:   state_d = dmcmp_pkg::S_LOOK;
      dmcmp_pkg::S_LOOK:   state_d = dmcmp_pkg::S_UPDATE;
      dmcmp_pkg::S_UPDATE: begin
        // hold until the output register can take the result
        if (status_i.out_free) state_d = dmcmp_pkg::S_IDLE;
      end
      default: state_d = dmcmp_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dmcmp_pkg::S_CLEAR: cmd_o.clr_en = 1'b1;
      dmcmp_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_addr = in_valid_i;
      end
      dmcmp_pkg::S_CALC:   cmd_o.calc_en = 1'b1;
      dmcmp_pkg::S_LOOK:   cmd_o.span_en = 1'b1;
      dmcmp_pkg::S_UPDATE: cmd_o.update_en = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dmcmp_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dmcmp_dpath #(
  parameter int unsigned SETS      = 4096,
  parameter int unsigned MAP_LINES = 65536,
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire dmcmp_pkg::ctrl_cmd_t                   cmd_i,
  output dmcmp_pkg::ctrl_status_t                     status_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [dmcmp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [dmcmp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [ADDR_BITS-1:0]                   in_addr_i,
  output logic                                        out_valid_o,
  output logic      [dmcmp_pkg::OUT_DATA_W-1:0]       out_data_o,
  input  wire logic                                   out_ready_i
);

  localparam int unsigned TAG_W     = ADDR_BITS - dmcmp_pkg::LINE_SHIFT;
  localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned MAP_ROWS  = (MAP_LINES + dmcmp_pkg::MAP_ROW_BITS - 1)
                                      / dmcmp_pkg::MAP_ROW_BITS;
  localparam int unsigned ROW_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned CLR_LEN   = (SETS > MAP_ROWS) ? SETS : MAP_ROWS;
  localparam int unsigned CLR_W     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
  localparam int unsigned CW        = dmcmp_pkg::COUNT_W;
  localparam int unsigned RB        = dmcmp_pkg::MAP_ROW_BITS;

  // configuration registers
  logic [dmcmp_pkg::IDX_BITS_W-1:0]   idx_bits_q;
  logic [dmcmp_pkg::SPAN_BASE_W-1:0]  span_base_q;
  logic [dmcmp_pkg::SPAN_LINES_W-1:0] span_lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_bits_q   <= dmcmp_pkg::IDX_BITS_RST;
      span_base_q  <= dmcmp_pkg::SPAN_BASE_RST;
      span_lines_q <= dmcmp_pkg::SPAN_LINES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dmcmp_pkg::CFG_INDEX_BITS: idx_bits_q   <= cfg_data_i[dmcmp_pkg::IDX_BITS_W-1:0];
        dmcmp_pkg::CFG_SPAN_BASE:  span_base_q  <= cfg_data_i[dmcmp_pkg::SPAN_BASE_W-1:0];
        dmcmp_pkg::CFG_SPAN_LINES: span_lines_q <= cfg_data_i[dmcmp_pkg::SPAN_LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic [CLR_W-1:0] clr_cnt_q;
  logic             clr_tag, clr_map;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en && !status_o.clr_done) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_done = (clr_cnt_q == CLR_W'(CLR_LEN - 1));
  assign clr_tag = cmd_i.clr_en && (32'(clr_cnt_q) < 32'(SETS));
  assign clr_map = cmd_i.clr_en && (32'(clr_cnt_q) < 32'(MAP_ROWS));

  // probe pipeline
  logic [ADDR_BITS-1:0] addr_q;
  logic [TAG_W-1:0]     line_q;
  logic [SET_W-1:0]     set_q, set_d, set_mask;
  logic [TAG_W-1:0]     rel_q;
  logic                 below_q;
  logic                 in_span_q;
  logic [ADDR_BITS:0]   diff;
  logic [63:0]          line_ext, rel_ext;

  always_comb begin
    line_ext = 64'(addr_q[ADDR_BITS-1:dmcmp_pkg::LINE_SHIFT]);
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (32'(i) < 32'(idx_bits_q));
    end
    set_d = line_ext[SET_W-1:0] & set_mask & SET_W'(SETS - 1);
    diff  = {1'b0, addr_q} - {1'b0, ADDR_BITS'(span_base_q)};
  end

  assign rel_ext = 64'(rel_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_addr) begin
      addr_q <= in_addr_i;
    end
    if (cmd_i.calc_en) begin
      line_q  <= addr_q[ADDR_BITS-1:dmcmp_pkg::LINE_SHIFT];
      set_q   <= set_d;
      rel_q   <= diff[ADDR_BITS-1:dmcmp_pkg::LINE_SHIFT];
      below_q <= diff[ADDR_BITS];
    end
    if (cmd_i.span_en) begin
      in_span_q <= !below_q && (rel_ext < 64'(span_lines_q)) && (rel_ext < 64'(MAP_LINES));
    end
  end

  // tag store: {valid, line}
  logic             tag_we;
  logic [SET_W-1:0] tag_waddr;
  logic [TAG_W:0]   tag_wdata, tag_rdata;
  logic             hit, first;

  // distinct-line map rows
  logic             map_we;
  logic [ROW_W-1:0] map_waddr, map_raddr;
  logic [RB-1:0]    map_wdata, map_rdata;
  logic [dmcmp_pkg::MAP_BIT_W-1:0] map_bit;

  assign map_raddr = rel_ext[dmcmp_pkg::MAP_BIT_W +: ROW_W];
  assign map_bit   = rel_q[dmcmp_pkg::MAP_BIT_W-1:0];

  assign hit   = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == line_q);
  assign first = in_span_q && !map_rdata[map_bit];

  always_comb begin
    if (cmd_i.clr_en) begin
      tag_we    = clr_tag;
      tag_waddr = clr_cnt_q[SET_W-1:0];
      tag_wdata = '0;
      map_we    = clr_map;
      map_waddr = clr_cnt_q[ROW_W-1:0];
      map_wdata = '0;
    end else begin
      tag_we    = cmd_i.update_en && !hit;
      tag_waddr = set_q;
      tag_wdata = {1'b1, line_q};
      map_we    = cmd_i.update_en && first;
      map_waddr = map_raddr;
      map_wdata = map_rdata | (RB'(1) << map_bit);
    end
  end

  dmcmp_ram #(
    .WIDTH (TAG_W + 1),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (set_q),
    .rdata_o (tag_rdata)
  );

  dmcmp_ram #(
    .WIDTH (RB),
    .DEPTH (MAP_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // running counters
  logic [CW-1:0] touch_q, hit_cnt_q, miss_q, distinct_q, outside_q;
  logic [CW-1:0] touch_d, hit_cnt_d, miss_d, distinct_d, outside_d;

  always_comb begin
    touch_d    = touch_q + 1'b1;
    hit_cnt_d  = hit_cnt_q + CW'(hit);
    miss_d     = miss_q + CW'(!hit);
    distinct_d = distinct_q + CW'(first);
    outside_d  = outside_q + CW'(!in_span_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q    <= '0;
      hit_cnt_q  <= '0;
      miss_q     <= '0;
      distinct_q <= '0;
      outside_q  <= '0;
    end else if (cmd_i.update_en) begin
      touch_q    <= touch_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_q     <= miss_d;
      distinct_q <= distinct_d;
      outside_q  <= outside_d;
    end
  end

  // output register
  logic                            out_valid_q;
  logic [dmcmp_pkg::OUT_DATA_W-1:0] out_data_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update_en) begin
      out_data_q <= dmcmp_pkg::OUT_DATA_W'({outside_d, distinct_d, miss_d, hit_cnt_d,
                                            touch_d, !in_span_q, first, hit});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/direct_mapped_cache_miss_profiler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Cache hit/miss profiler. Each input beat carries one byte address; the block
// looks its 64-byte line up in a direct-mapped tag store, marks in-span lines
// in a one-bit-per-line map and returns one result beat with the hit,
// first-touch and out-of-span flags plus five wrapping 64-bit counters. An
// address passes capture, span subtract and set select, registered RAM read
// and tag/map read-modify-write in turn; the next address is taken only after
// that read-modify-write on the two single-port-read RAMs. A finished result
// waits in its own output register without blocking the next address, but the
// next read-modify-write holds until that register is free. After reset a
// clearing pass empties the tag store and the map; no address is taken until
// it ends, configuration writes are taken at any time.

module direct_mapped_cache_miss_profiler #(
  parameter int unsigned SETS      = 4096,
  parameter int unsigned MAP_LINES = 65536,
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [dmcmp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [dmcmp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // address
  input  wire logic [((ADDR_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // hit, first_touch, out_of_span, touch_count, hit_count, miss_count,
  // distinct_count, outside_count
  output logic      [dmcmp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  dmcmp_pkg::ctrl_cmd_t    cmd;
  dmcmp_pkg::ctrl_status_t status;

  dmcmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmcmp_dpath #(
    .SETS      (SETS),
    .MAP_LINES (MAP_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_addr_i   (s_axis_tdata[ADDR_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

endmodule

`default_nettype wire
